### sv/svc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svc_pkg;

  typedef enum logic [1:0] {
    ST_TURN   = 2'd0,
    ST_DRIVE  = 2'd1,
    ST_DONE   = 2'd2,
    ST_PAUSED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_SPEED     = 2'd0,
    REG_MAX_ACCEL     = 2'd1,
    REG_MAX_TURN_RATE = 2'd2
  } reg_index_e;

  localparam int HALF_TURN_LIMIT = 3141;
  localparam int FULL_TURN       = 6283;
  localparam int ROTATE_DONE     = 51;
  localparam int DEADBAND        = 10;
  localparam int ARRIVE_SQ       = 225;
  localparam int SHORT_SQ        = 1000000;
  localparam int SHORT_SPEED     = 200;
  localparam int CFG_RESET       = 500;

  // sideband that travels with each request through the pipeline
  typedef struct packed {
    logic               valid;
    logic [4:0]         tag;
    status_e            status;
    logic signed [12:0] ang;
    logic               line_go;
    logic               short_seg;
    logic               use_root;
  } side_t;

endpackage

`default_nettype wire

### sv/svc_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module svc_sqrt #(
  parameter int IN_W = 34
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [IN_W-1:0]            rad_i,
  output logic      [(IN_W+1)/2-1:0]      root_o
);

  localparam int N  = (IN_W + 1) / 2;
  localparam int W2 = 2 * N;
  localparam int RW = N + 2;

  logic [W2-1:0] rad_q  [N];
  logic [RW-1:0] rem_q  [N];
  logic [N-1:0]  root_q [N];

  logic [W2-1:0] rad_s  [N+1];
  logic [RW-1:0] rem_s  [N+1];
  logic [N-1:0]  root_s [N+1];

  logic [W2-1:0] rad_d  [N];
  logic [RW-1:0] rem_d  [N];
  logic [N-1:0]  root_d [N];

  always_comb begin
    rad_s[0]  = W2'(rad_i);
    rem_s[0]  = '0;
    root_s[0] = '0;
    for (int k = 0; k < N; k++) begin
      rad_s[k+1]  = rad_q[k];
      rem_s[k+1]  = rem_q[k];
      root_s[k+1] = root_q[k];
    end
  end

  // one root bit per stage
  always_comb begin
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    for (int k = 0; k < N; k++) begin
      rem_t = {rem_s[k], rad_s[k][W2-1 -: 2]};
      trial = (RW+2)'({root_s[k], 2'b01});
      rad_d[k] = rad_s[k] << 2;
      if (rem_t >= trial) begin
        rem_d[k]  = RW'(rem_t - trial);
        root_d[k] = {root_s[k][N-2:0], 1'b1};
      end else begin
        rem_d[k]  = RW'(rem_t);
        root_d[k] = {root_s[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

`default_nettype wire

### sv/segment_velocity_command.sv
// Speed command for one control tick of one robot.
// Input channel: one request per tick with the robot index, obstacle flag,
// segment kind, rotate target heading, line end points and the pose. It is
// taken when in_valid_i is high and in_stall_o is low.
// Output channel: one result per request, in order, with the robot tag,
// forward speed, turn rate and status; taken when out_valid_o is high and
// out_stall_i is low.
// Config channel: cfg_index_i selects max_speed (0), max_accel (1) or max_turn_rate
// (2); always ready; the user must write it only while no request is in flight (unenforced).
// Throughput: one request per cycle unless the output stalls. Path: stages
// 1-3, square-root pipeline of depth R1 = ceil(min(2*COORD_BITS+1, 64)/2),
// stages 4-6, square-root pipeline of depth R2 = ceil((R1+14)/2), output register.
// A stall on a valid output freezes the whole pipeline and raises in_stall_o in
// the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets the three registers to 500.
`timescale 1ns / 1ps
`default_nettype none

module segment_velocity_command #(
  parameter int COORD_BITS  = 17,
  parameter int ROBOT_COUNT = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [12:0]                  cfg_data_i,

  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [4:0]                   robot_index_i,
  input  wire logic                         obstacle_ahead_i,
  input  wire logic                         segment_is_line_i,
  input  wire logic signed [12:0]           target_heading_i,
  input  wire logic signed [COORD_BITS-1:0] line_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] line_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] line_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] line_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] pose_x_i,
  input  wire logic signed [COORD_BITS-1:0] pose_y_i,
  input  wire logic signed [12:0]           pose_heading_i,

  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [4:0]                        robot_tag_o,
  output logic [11:0]                       linear_speed_o,
  output logic signed [12:0]                angular_speed_o,
  output logic [1:0]                        status_o
);

  localparam int C      = COORD_BITS;
  localparam int SQ_W   = 2 * C;
  localparam int SUM_W  = SQ_W + 1;
  localparam int SAT_W  = (SUM_W > 64) ? 64 : SUM_W;
  localparam int RW     = (SAT_W + 1) / 2;
  localparam int MW     = RW + 15;
  localparam int PW     = RW + 14;
  localparam int VW     = (PW + 1) / 2;

  localparam logic signed [13:0] HalfTurn = 14'(svc_pkg::HALF_TURN_LIMIT);
  localparam logic signed [13:0] FullTurn = 14'(svc_pkg::FULL_TURN);
  localparam logic signed [13:0] DoneLim  = 14'(svc_pkg::ROTATE_DONE);

  // configuration
  logic [11:0] max_speed_q;
  logic [12:0] max_accel_q;
  logic [11:0] max_turn_q;
  logic [13:0] accel2_q;
  logic [23:0] speed_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= 12'(svc_pkg::CFG_RESET);
      max_accel_q <= 13'(svc_pkg::CFG_RESET);
      max_turn_q  <= 12'(svc_pkg::CFG_RESET);
    end else if (cfg_valid_i) begin
      case (svc_pkg::reg_index_e'(cfg_index_i))
        svc_pkg::REG_MAX_SPEED:     max_speed_q <= cfg_data_i[11:0];
        svc_pkg::REG_MAX_ACCEL:     max_accel_q <= cfg_data_i;
        svc_pkg::REG_MAX_TURN_RATE: max_turn_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // derived config terms; the user must keep config static while requests are in flight (unenforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel2_q   <= '0;
      speed_sq_q <= '0;
    end else begin
      accel2_q   <= {(max_accel_q == '0) ? 13'd1 : max_accel_q, 1'b0};
      speed_sq_q <= 24'(max_speed_q) * 24'(max_speed_q);
    end
  end

  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: heading error, paused decision, coordinate deltas
  logic signed [13:0] hd_raw, hd_wrap;
  logic signed [12:0] turn_pos;
  logic               paused;
  svc_pkg::side_t     side1_d, side1_q;
  logic [C-1:0]       ep_dx_d, ep_dy_d, es_dx_d, es_dy_d, ps_dx_d, ps_dy_d;
  logic [C-1:0]       ep_dx_q, ep_dy_q, es_dx_q, es_dy_q, ps_dx_q, ps_dy_q;

  function automatic logic [C-1:0] abs_diff(logic signed [C-1:0] a,
                                            logic signed [C-1:0] b);
    logic signed [C:0] dif;
    dif = {a[C-1], a} - {b[C-1], b};
    return dif[C] ? C'(-dif) : C'(dif);
  endfunction

  always_comb begin
    paused   = obstacle_ahead_i || ({4'd0, robot_index_i} >= 9'(ROBOT_COUNT));
    hd_raw   = {target_heading_i[12], target_heading_i}
             - {pose_heading_i[12], pose_heading_i};
    if (hd_raw > HalfTurn) begin
      hd_wrap = hd_raw - FullTurn;
    end else if (hd_raw < -HalfTurn) begin
      hd_wrap = hd_raw + FullTurn;
    end else begin
      hd_wrap = hd_raw;
    end
    turn_pos = $signed({1'b0, max_turn_q});

    side1_d           = '0;
    side1_d.valid     = in_valid_i;
    side1_d.tag       = robot_index_i;
    side1_d.ang       = '0;
    if (paused) begin
      side1_d.status  = svc_pkg::ST_PAUSED;
    end else if (!segment_is_line_i) begin
      if (hd_wrap < DoneLim && hd_wrap > -DoneLim) begin
        side1_d.status = svc_pkg::ST_DONE;
      end else begin
        side1_d.status = svc_pkg::ST_TURN;
        if (max_turn_q >= 12'(svc_pkg::DEADBAND)) begin
          side1_d.ang = (hd_wrap > 14'sd0) ? turn_pos : -turn_pos;
        end
      end
    end else begin
      side1_d.status  = svc_pkg::ST_DRIVE;
      side1_d.line_go = 1'b1;
    end

    ep_dx_d = abs_diff(line_end_x_i, pose_x_i);
    ep_dy_d = abs_diff(line_end_y_i, pose_y_i);
    es_dx_d = abs_diff(line_end_x_i, line_start_x_i);
    es_dy_d = abs_diff(line_end_y_i, line_start_y_i);
    ps_dx_d = abs_diff(pose_x_i, line_start_x_i);
    ps_dy_d = abs_diff(pose_y_i, line_start_y_i);
  end

  // stage 2: squares
  svc_pkg::side_t side2_q;
  logic [SQ_W-1:0] ep_sx_q, ep_sy_q, es_sx_q, es_sy_q, ps_sx_q, ps_sy_q;

  // stage 3: sums, arrival and short-segment checks
  svc_pkg::side_t  side3_d, side3_q;
  logic [SUM_W-1:0] ep_sum, es_sum, ps_sum;
  logic [SAT_W-1:0] ep_sat, es_sat, ps_sat;
  logic [SAT_W-1:0] tot_sq_q, now_sq_q;

  function automatic logic [SAT_W-1:0] sat_sum(logic [SUM_W-1:0] s);
    return (|(s >> SAT_W)) ? {SAT_W{1'b1}} : s[SAT_W-1:0];
  endfunction

  always_comb begin
    ep_sum = SUM_W'(ep_sx_q) + SUM_W'(ep_sy_q);
    es_sum = SUM_W'(es_sx_q) + SUM_W'(es_sy_q);
    ps_sum = SUM_W'(ps_sx_q) + SUM_W'(ps_sy_q);
    ep_sat = sat_sum(ep_sum);
    es_sat = sat_sum(es_sum);
    ps_sat = sat_sum(ps_sum);
    side3_d = side2_q;
    if (side2_q.line_go) begin
      side3_d.short_seg = es_sat < SAT_W'(svc_pkg::SHORT_SQ);
      if (ep_sat < SAT_W'(svc_pkg::ARRIVE_SQ)) begin
        side3_d.line_go = 1'b0;
        side3_d.status  = svc_pkg::ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ep_dx_q  <= ep_dx_d;
      ep_dy_q  <= ep_dy_d;
      es_dx_q  <= es_dx_d;
      es_dy_q  <= es_dy_d;
      ps_dx_q  <= ps_dx_d;
      ps_dy_q  <= ps_dy_d;
      ep_sx_q  <= SQ_W'(ep_dx_q) * SQ_W'(ep_dx_q);
      ep_sy_q  <= SQ_W'(ep_dy_q) * SQ_W'(ep_dy_q);
      es_sx_q  <= SQ_W'(es_dx_q) * SQ_W'(es_dx_q);
      es_sy_q  <= SQ_W'(es_dy_q) * SQ_W'(es_dy_q);
      ps_sx_q  <= SQ_W'(ps_dx_q) * SQ_W'(ps_dx_q);
      ps_sy_q  <= SQ_W'(ps_dy_q) * SQ_W'(ps_dy_q);
      tot_sq_q <= es_sat;
      now_sq_q <= ps_sat;
    end
  end

  // segment length and distance travelled
  logic [RW-1:0] total_root, now_root;

  svc_sqrt #(.IN_W(SAT_W)) u_sqrt_total (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (tot_sq_q),
    .root_o (total_root)
  );

  svc_sqrt #(.IN_W(SAT_W)) u_sqrt_now (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (now_sq_q),
    .root_o (now_root)
  );

  svc_pkg::side_t side_r1_q [RW];

  // stage 4: ramp products, ramp = speed^2 / (2 accel) is compared by multiplying
  svc_pkg::side_t side4_q;
  logic [RW-1:0]  now_q, tot_q;
  logic           tot_lt_q;
  logic [MW-1:0]  m_head_q, m_tail_q;
  logic [RW:0]    now_p1, gap_p1;

  always_comb begin
    now_p1 = (RW+1)'(now_root) + (RW+1)'(1);
    gap_p1 = (RW+1)'(total_root - now_root) + (RW+1)'(1);
  end

  // stage 5: profile region and ramp distance
  svc_pkg::side_t side5_d, side5_q;
  logic [RW-1:0]  x_d, x_q;
  logic           in_head, in_tail;

  always_comb begin
    in_head = m_head_q <= MW'(speed_sq_q);
    in_tail = tot_lt_q || (MW'(speed_sq_q) >= m_tail_q);
    side5_d = side4_q;
    side5_d.use_root = in_head || in_tail;
    if (in_head) begin
      x_d = now_q;
    end else if (tot_lt_q) begin
      x_d = '0;
    end else begin
      x_d = tot_q - now_q;
    end
  end

  // stage 6: 2 * accel * distance
  svc_pkg::side_t side6_q;
  logic [PW-1:0]  prod_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      now_q    <= now_root;
      tot_q    <= total_root;
      tot_lt_q <= total_root < now_root;
      m_head_q <= MW'(now_p1) * MW'(accel2_q);
      m_tail_q <= MW'(gap_p1) * MW'(accel2_q);
      x_q      <= x_d;
      prod_q   <= PW'(x_q) * PW'(accel2_q);
    end
  end

  logic [VW-1:0] ramp_root;

  svc_sqrt #(.IN_W(PW)) u_sqrt_ramp (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (prod_q),
    .root_o (ramp_root)
  );

  svc_pkg::side_t side_r2_q [VW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
      side6_q <= '0;
      for (int k = 0; k < RW; k++) side_r1_q[k] <= '0;
      for (int k = 0; k < VW; k++) side_r2_q[k] <= '0;
    end else if (adv) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
      side3_q <= side3_d;
      side_r1_q[0] <= side3_q;
      for (int k = 1; k < RW; k++) side_r1_q[k] <= side_r1_q[k-1];
      side4_q <= side_r1_q[RW-1];
      side5_q <= side5_d;
      side6_q <= side5_q;
      side_r2_q[0] <= side6_q;
      for (int k = 1; k < VW; k++) side_r2_q[k] <= side_r2_q[k-1];
    end
  end

  // output stage
  svc_pkg::side_t side_o;
  logic [VW-1:0]  v_sel;
  logic [11:0]    lin_d;

  always_comb begin
    side_o = side_r2_q[VW-1];
    if (side_o.short_seg) begin
      v_sel = VW'(svc_pkg::SHORT_SPEED);
    end else if (side_o.use_root) begin
      v_sel = ramp_root;
    end else begin
      v_sel = VW'(max_speed_q);
    end
    lin_d = (side_o.line_go && v_sel >= VW'(svc_pkg::DEADBAND)) ? v_sel[11:0] : '0;
  end

  logic [4:0]         tag_q;
  logic [11:0]        lin_q;
  logic signed [12:0] ang_q;
  svc_pkg::status_e   status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_o.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q    <= side_o.tag;
      lin_q    <= lin_d;
      ang_q    <= side_o.ang;
      status_q <= side_o.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign robot_tag_o     = tag_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

### sv/svc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module svc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [4:0]                   robot_tag_o,
  input wire logic [11:0]                  linear_speed_o,
  input wire logic signed [12:0]           angular_speed_o,
  input wire logic [1:0]                   status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(robot_tag_o)
      && $stable(linear_speed_o) && $stable(angular_speed_o) && $stable(status_o))
    else $error("stalled result changed");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == svc_pkg::ST_PAUSED || status_o == svc_pkg::ST_DONE)
      |-> linear_speed_o == '0 && angular_speed_o == '0)
    else $error("speed while paused or done");

  a_drive_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == svc_pkg::ST_DRIVE |-> angular_speed_o == '0)
    else $error("turn rate while driving");

  a_turn_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == svc_pkg::ST_TURN |-> linear_speed_o == '0)
    else $error("forward speed while turning");

endmodule

bind segment_velocity_command svc_checker u_svc_checker (.*);

`default_nettype wire

### test/segment_velocity_command_tb.sv
`timescale 1ns / 1ps

module segment_velocity_command_tb;

  localparam int CB = 17;
  localparam int RAND_ITEMS = 618;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [4:0]           robot;
    logic                 obstacle;
    logic                 is_line;
    logic signed [12:0]   tgt_head;
    logic signed [CB-1:0] sx, sy, ex, ey, px, py;
    logic signed [12:0]   pose_head;
  } tick_t;

  typedef struct {
    logic [4:0]         tag;
    logic [11:0]        lin;
    logic signed [12:0] ang;
    svc_pkg::status_e   status;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [4:0] robot_index_i = '0;
  logic obstacle_ahead_i = 1'b0;
  logic segment_is_line_i = 1'b0;
  logic signed [12:0] target_heading_i = '0;
  logic signed [CB-1:0] line_start_x_i = '0, line_start_y_i = '0;
  logic signed [CB-1:0] line_end_x_i = '0, line_end_y_i = '0;
  logic signed [CB-1:0] pose_x_i = '0, pose_y_i = '0;
  logic signed [12:0] pose_heading_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [4:0] robot_tag_o;
  logic [11:0] linear_speed_o;
  logic signed [12:0] angular_speed_o;
  logic [1:0] status_o;

  segment_velocity_command #(.COORD_BITS(CB), .ROBOT_COUNT(32)) dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor's copy of the registers
  logic [11:0] speed_lim = 12'd500;
  logic [12:0] accel_lim = 13'd500;
  logic [11:0] turn_lim = 12'd500;

  tick_t pending_ticks[$];
  command_t expected_cmds[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  longint cycles = 0;
  bit feeding_done = 0;

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_span(longint ax, longint ay, longint bx, longint by);
    longint unsigned dx, dy;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  function automatic command_t speed_command(tick_t t);
    command_t c;
    longint d, sx, sy, ex, ey, px, py;
    longint unsigned a, tot_sq, total, now, ramp, v, rem;
    c.tag = t.robot;
    c.lin = '0;
    c.ang = '0;
    if (t.obstacle) begin
      c.status = svc_pkg::ST_PAUSED;
    end else if (!t.is_line) begin
      d = longint'(t.tgt_head) - longint'(t.pose_head);
      while (d > svc_pkg::HALF_TURN_LIMIT) d -= svc_pkg::FULL_TURN;
      while (d < -svc_pkg::HALF_TURN_LIMIT) d += svc_pkg::FULL_TURN;
      if (d < svc_pkg::ROTATE_DONE && d > -svc_pkg::ROTATE_DONE) begin
        c.status = svc_pkg::ST_DONE;
      end else begin
        c.status = svc_pkg::ST_TURN;
        if (turn_lim >= svc_pkg::DEADBAND)
          c.ang = (d > 0) ? $signed({1'b0, turn_lim}) : -$signed({1'b0, turn_lim});
      end
    end else begin
      sx = t.sx; sy = t.sy; ex = t.ex; ey = t.ey; px = t.px; py = t.py;
      if (sq_span(ex, ey, px, py) < svc_pkg::ARRIVE_SQ) begin
        c.status = svc_pkg::ST_DONE;
      end else begin
        c.status = svc_pkg::ST_DRIVE;
        a = (accel_lim != 0) ? accel_lim : 1;
        tot_sq = sq_span(ex, ey, sx, sy);
        total = root_floor(tot_sq);
        now = root_floor(sq_span(px, py, sx, sy));
        ramp = (longint'(speed_lim) * speed_lim) / (2 * a);
        if (tot_sq < svc_pkg::SHORT_SQ) v = svc_pkg::SHORT_SPEED;
        else if (now < ramp) v = root_floor(2 * a * now);
        else if (now + ramp > total) begin
          rem = (total > now) ? total - now : 0;
          v = root_floor(2 * a * rem);
        end else v = speed_lim;
        if (v >= svc_pkg::DEADBAND) c.lin = v[11:0];
      end
    end
    return c;
  endfunction

  task automatic queue_tick(tick_t t);
    pending_ticks = {pending_ticks, t};
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (in_valid_i) sent <= sent + 1;
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        end
        if (burst_left > 0 && pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          burst_left--;
          expected_cmds = {expected_cmds, speed_command(t)};
          in_valid_i <= 1'b1;
          robot_index_i <= t.robot;
          obstacle_ahead_i <= t.obstacle;
          segment_is_line_i <= t.is_line;
          target_heading_i <= t.tgt_head;
          line_start_x_i <= t.sx;
          line_start_y_i <= t.sy;
          line_end_x_i <= t.ex;
          line_end_y_i <= t.ey;
          pose_x_i <= t.px;
          pose_y_i <= t.py;
          pose_heading_i <= t.pose_head;
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
          else burst_left = 0;
        end
      end
    end
  end

  // receiver stall pattern: modes change every so often
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 120);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      received <= received + 1;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result tag=%0d", $time, robot_tag_o);
        errors++;
      end else begin
        command_t e;
        e = expected_cmds.pop_front();
        if (robot_tag_o !== e.tag || linear_speed_o !== e.lin ||
            angular_speed_o !== e.ang || status_o !== e.status) begin
          $display("%0t: mismatch expected tag=%0d lin=%0d ang=%0d st=%0d",
                   $time, e.tag, e.lin, e.ang, e.status);
          $display("%0t:          actual   tag=%0d lin=%0d ang=%0d st=%0d",
                   $time, robot_tag_o, linear_speed_o, angular_speed_o, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $signed(CB'($urandom()));
      1: return -(CB'(1) << (CB - 1));
      2: return (CB'(1) << (CB - 1)) - 1;
      default: return $signed(CB'($urandom_range(0, 8000))) - 4000;
    endcase
  endfunction

  function automatic logic signed [12:0] rand_head();
    return $signed(13'($urandom_range(0, 6284))) - 13'sd3142;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int unsigned len;
    int along;
    longint dxl, dyl;
    t.robot = $urandom();
    t.obstacle = ($urandom_range(0, 9) == 0);
    t.is_line = $urandom_range(0, 1);
    t.tgt_head = rand_head();
    t.pose_head = ($urandom_range(0, 3) == 0) ? t.tgt_head + $signed(13'($urandom_range(0, 120)))
                  - 13'sd60 : rand_head();
    if ($urandom_range(0, 4) == 0) begin
      t.sx = rand_coord(); t.sy = rand_coord();
      t.ex = rand_coord(); t.ey = rand_coord();
      t.px = rand_coord(); t.py = rand_coord();
    end else begin
      // well-formed segment with pose near the line
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1200) : $urandom_range(1000, 20000);
      t.sx = $signed(CB'($urandom_range(0, 40000))) - 20000;
      t.sy = $signed(CB'($urandom_range(0, 40000))) - 20000;
      dxl = $urandom_range(0, len);
      dyl = root_floor(longint'(len) * len - dxl * dxl);
      if ($urandom_range(0, 1)) dxl = -dxl;
      if ($urandom_range(0, 1)) dyl = -dyl;
      t.ex = t.sx + dxl;
      t.ey = t.sy + dyl;
      along = $urandom_range(0, 1100);
      t.px = t.sx + dxl * along / 1000 + $signed(CB'($urandom_range(0, 40))) - 20;
      t.py = t.sy + dyl * along / 1000 + $signed(CB'($urandom_range(0, 40))) - 20;
    end
    return t;
  endfunction

  task automatic write_reg(svc_pkg::reg_index_e idx, logic [12:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      svc_pkg::REG_MAX_SPEED: speed_lim = value[11:0];
      svc_pkg::REG_MAX_ACCEL: accel_lim = value;
      default: turn_lim = value[11:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() > 0 || expected_cmds.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_directed();
    tick_t t;
    t = '{default: '0};
    t.obstacle = 1; t.is_line = 1; queue_tick(t);
    t.obstacle = 0; t.robot = 5'd31; t.is_line = 0;
    t.tgt_head = 13'sd3142; t.pose_head = -13'sd3142; queue_tick(t);
    t.tgt_head = 13'sd50; t.pose_head = 13'sd0; queue_tick(t);
    t.tgt_head = -13'sd51; queue_tick(t);
    t.tgt_head = 13'sd51; queue_tick(t);
    t.tgt_head = -13'sd3142; t.pose_head = 13'sd100; queue_tick(t);
    t.tgt_head = 13'sd3000; t.pose_head = -13'sd3000; queue_tick(t);
    t.is_line = 1;
    t.sx = 0; t.sy = 0; t.ex = 5000; t.ey = 0;
    t.px = 4990; t.py = 10; queue_tick(t);
    t.px = 4985; t.py = 0; queue_tick(t);
    t.px = 0; queue_tick(t);
    t.px = 100; queue_tick(t);
    t.px = 2500; queue_tick(t);
    t.px = 4900; queue_tick(t);
    t.px = 6000; queue_tick(t);
    t.ex = 999; t.px = 300; queue_tick(t);
    t.ex = 1000; queue_tick(t);
    t.sx = -(CB'(1) << (CB - 1)); t.sy = t.sx;
    t.ex = (CB'(1) << (CB - 1)) - 1; t.ey = t.ex;
    t.px = t.sx; t.py = t.ex; queue_tick(t);
    t.px = t.ex; t.py = t.sx; queue_tick(t);
    t.robot = 5'h15; t.tgt_head = 13'sh0AAA; t.pose_head = -13'sh0555;
    t.sx = 17'h0AAAA; t.px = 17'h15555; t.obstacle = 1; queue_tick(t);
  endtask

  initial begin
    int setting;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    wait_idle();
    for (setting = 0; setting < 6; setting++) begin
      case (setting)
        0: begin write_reg(svc_pkg::REG_MAX_SPEED, 13'd4000);
                 write_reg(svc_pkg::REG_MAX_ACCEL, 13'd8000);
                 write_reg(svc_pkg::REG_MAX_TURN_RATE, 13'd4000); end
        1: begin write_reg(svc_pkg::REG_MAX_SPEED, 13'd0);
                 write_reg(svc_pkg::REG_MAX_ACCEL, 13'd1);
                 write_reg(svc_pkg::REG_MAX_TURN_RATE, 13'd0); end
        2: begin write_reg(svc_pkg::REG_MAX_SPEED, 13'd4000);
                 write_reg(svc_pkg::REG_MAX_ACCEL, 13'd1);
                 write_reg(svc_pkg::REG_MAX_TURN_RATE, 13'd9); end
        3: begin write_reg(svc_pkg::REG_MAX_SPEED, 13'd4095);
                 write_reg(svc_pkg::REG_MAX_ACCEL, 13'd0);
                 write_reg(svc_pkg::REG_MAX_TURN_RATE, 13'd10); end
        4: begin write_reg(svc_pkg::REG_MAX_SPEED, 13'd1500);
                 write_reg(svc_pkg::REG_MAX_ACCEL, 13'd8191);
                 write_reg(svc_pkg::REG_MAX_TURN_RATE, 13'd4095); end
        default: begin write_reg(svc_pkg::REG_MAX_SPEED, 13'($urandom_range(0, 4000)));
                 write_reg(svc_pkg::REG_MAX_ACCEL, 13'($urandom_range(1, 8000)));
                 write_reg(svc_pkg::REG_MAX_TURN_RATE, 13'($urandom_range(0, 4000))); end
      endcase
      add_directed();
      repeat (RAND_ITEMS / 6) queue_tick(rand_tick());
      wait_idle();
    end
    $display("covered %0d requests, %0d results, over 7 register settings incl. extremes",
             sent, received);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
